// File: rtl/owbm_pkg.sv
package owbm_pkg;

  localparam int CNT_W   = 10;
  localparam int REG_W   = 10;
  localparam int EXT_W   = (CNT_W > REG_W) ? CNT_W : REG_W;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_RESET_LOW     = 3'd0,
    REG_RESET_RELEASE = 3'd1,
    REG_PRES_WAIT     = 3'd2,
    REG_PRES_MAX      = 3'd3,
    REG_SLOT_SHORT    = 3'd4,
    REG_SLOT_LONG     = 3'd5,
    REG_READ_SAMPLE   = 3'd6,
    REG_READ_RECOVER  = 3'd7
  } reg_idx_t;

  typedef enum logic [9:0] {
    PH_IDLE      = 10'b0000000001,
    PH_RST_LOW   = 10'b0000000010,
    PH_RST_REL   = 10'b0000000100,
    PH_PRES_WAIT = 10'b0000001000,
    PH_PRES_LOW  = 10'b0000010000,
    PH_W_LOW     = 10'b0000100000,
    PH_W_HIGH    = 10'b0001000000,
    PH_R_LOW     = 10'b0010000000,
    PH_R_WAIT    = 10'b0100000000,
    PH_R_REC     = 10'b1000000000
  } phase_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       cmd_rejected;
    logic [7:0] rx_byte;
    logic       presence_fail;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } result_t;

  typedef struct packed {
    logic [9:0] reset_low_ticks;
    logic [9:0] reset_release_ticks;
    logic [9:0] presence_wait_ticks;
    logic [9:0] presence_max_ticks;
    logic [7:0] slot_short_ticks;
    logic [7:0] slot_long_ticks;
    logic [7:0] read_sample_ticks;
    logic [7:0] read_recover_ticks;
  } cfg_t;

  // A zero setting acts as one tick; settings beyond the counter saturate.
  function automatic logic [CNT_W-1:0] limit_of(input logic [REG_W-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    if (ext == '0) begin
      return CNT_W'(1);
    end else if (ext > EXT_W'(CNT_MAX)) begin
      return CNT_MAX;
    end else begin
      return ext[CNT_W-1:0];
    end
  endfunction

endpackage

// File: rtl/owbm_front.sv
module owbm_front
  import owbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  output logic        q_valid,
  output item_t       q_head,
  input  logic        q_pop
);

  item_t       entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_head   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: rtl/owbm_engine.sv
module owbm_engine
  import owbm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  item_t   q_head,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] tick_count, tick_count_next;
  logic [2:0]       bit_index, bit_index_next;
  logic [7:0]       shift_reg, shift_reg_next;
  logic             fail_flag, fail_flag_next;
  logic [7:0]       rx_hold, rx_hold_next;

  phase_t           ph;
  logic [CNT_W-1:0] tc, tc_inc, lim;
  logic [REG_W-1:0] lim_raw;
  logic [2:0]       bi;
  logic [7:0]       sr;
  logic             ff, rej, drive, done, bit_val, expired, line;
  result_t          res;

  assign q_pop = q_valid && (!out_valid || out_ready);
  assign line  = q_head.line_level;

  always_comb begin
    ph  = phase;
    tc  = tick_count;
    bi  = bit_index;
    sr  = shift_reg;
    ff  = fail_flag;
    rej = 1'b0;

    if (q_head.cmd != CMD_TICK) begin
      if (phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        tc = '0;
        bi = '0;
        ff = 1'b0;
        unique case (q_head.cmd)
          CMD_RESET: ph = PH_RST_LOW;
          CMD_WRITE: begin
            ph = PH_W_LOW;
            sr = q_head.tx_byte;
          end
          CMD_READ: begin
            ph = PH_R_LOW;
            sr = '0;
          end
          default: ph = PH_IDLE;
        endcase
      end
    end

    drive   = (ph == PH_RST_LOW) || (ph == PH_W_LOW) || (ph == PH_R_LOW);
    bit_val = sr[0];

    // One limit per phase, so a single compare serves every timed phase.
    unique case (ph)
      PH_RST_LOW:   lim_raw = cfg.reset_low_ticks;
      PH_RST_REL:   lim_raw = cfg.reset_release_ticks;
      PH_PRES_WAIT: lim_raw = cfg.presence_wait_ticks;
      PH_PRES_LOW:  lim_raw = cfg.presence_max_ticks;
      PH_W_LOW:     lim_raw = REG_W'(bit_val ? cfg.slot_short_ticks : cfg.slot_long_ticks);
      PH_W_HIGH:    lim_raw = REG_W'(bit_val ? cfg.slot_long_ticks : cfg.slot_short_ticks);
      PH_R_LOW:     lim_raw = REG_W'(cfg.slot_short_ticks);
      PH_R_WAIT:    lim_raw = REG_W'(cfg.read_sample_ticks);
      PH_R_REC:     lim_raw = REG_W'(cfg.read_recover_ticks);
      default:      lim_raw = '0;
    endcase
    lim     = limit_of(lim_raw);
    tc_inc  = tc + CNT_W'(1);
    expired = (tc_inc >= lim);

    phase_next      = ph;
    tick_count_next = expired ? '0 : tc_inc;
    bit_index_next  = bi;
    shift_reg_next  = sr;
    fail_flag_next  = ff;
    rx_hold_next    = rx_hold;
    done            = 1'b0;

    unique case (ph)
      PH_IDLE: begin
        tick_count_next = tc;
      end
      PH_RST_LOW: begin
        if (expired) phase_next = PH_RST_REL;
      end
      PH_RST_REL: begin
        if (expired) phase_next = PH_PRES_WAIT;
      end
      PH_PRES_WAIT: begin
        if (line) begin
          if (expired) begin
            done = 1'b1;
            fail_flag_next = 1'b1;
          end
        end else begin
          // The first low sample already counts toward the presence limit.
          phase_next      = PH_PRES_LOW;
          tick_count_next = CNT_W'(1);
          if (limit_of(cfg.presence_max_ticks) == CNT_W'(1)) begin
            done = 1'b1;
            fail_flag_next = 1'b1;
          end
        end
      end
      PH_PRES_LOW: begin
        if (line) begin
          done = 1'b1;
          fail_flag_next = 1'b0;
        end else if (expired) begin
          done = 1'b1;
          fail_flag_next = 1'b1;
        end
      end
      PH_W_LOW: begin
        if (expired) phase_next = PH_W_HIGH;
      end
      PH_W_HIGH: begin
        if (expired) begin
          shift_reg_next = {1'b0, sr[7:1]};
          if (bi == 3'd7) begin
            done = 1'b1;
            fail_flag_next = 1'b0;
          end else begin
            bit_index_next = bi + 3'd1;
            phase_next     = PH_W_LOW;
          end
        end
      end
      PH_R_LOW: begin
        if (expired) phase_next = PH_R_WAIT;
      end
      PH_R_WAIT: begin
        if (expired) begin
          shift_reg_next = {line, sr[7:1]};
          phase_next     = PH_R_REC;
        end
      end
      PH_R_REC: begin
        if (expired) begin
          if (bi == 3'd7) begin
            rx_hold_next   = sr;
            done           = 1'b1;
            fail_flag_next = 1'b0;
          end else begin
            bit_index_next = bi + 3'd1;
            phase_next     = PH_R_LOW;
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = tc;
      end
    endcase

    if (done) begin
      phase_next      = PH_IDLE;
      tick_count_next = '0;
      bit_index_next  = '0;
    end

    res.drive_low     = drive;
    res.busy_res      = (phase_next != PH_IDLE);
    res.done_res      = done;
    res.presence_fail = done && fail_flag_next;
    res.rx_byte       = rx_hold_next;
    res.cmd_rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bit_index  <= '0;
      shift_reg  <= '0;
      fail_flag  <= 1'b0;
      rx_hold    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (q_pop) begin
        phase      <= phase_next;
        tick_count <= tick_count_next;
        bit_index  <= bit_index_next;
        shift_reg  <= shift_reg_next;
        fail_flag  <= fail_flag_next;
        rx_hold    <= rx_hold_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_res <= res;
    end
  end

endmodule

// File: rtl/one_wire_bus_master.sv
// A result beat leaves from the output register after its input beat has
// passed the two-entry input queue. Throughput: one beat per cycle; the
// tick engine retires one queued beat per cycle unless a held result stalls it.
// Reset (rst, synchronous, active high) empties the queue, returns the engine
// to idle with cleared counters and read byte, and loads the timing defaults.
module one_wire_bus_master
  import owbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // [7:0] tx_byte, [8] line_level, rest zero
  input  logic [1:0]        s_tuser,   // [1:0] cmd
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
                                       // [3] presence_fail, [11:4] rx_byte,
                                       // [12] cmd_rejected, rest zero
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  item_t    in_item;
  item_t    q_head;
  logic     q_valid, q_pop;
  result_t  out_res;
  reg_idx_t reg_sel;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks     <= 10'd750;
      cfg.reset_release_ticks <= 10'd15;
      cfg.presence_wait_ticks <= 10'd200;
      cfg.presence_max_ticks  <= 10'd240;
      cfg.slot_short_ticks    <= 8'd2;
      cfg.slot_long_ticks     <= 8'd60;
      cfg.read_sample_ticks   <= 8'd12;
      cfg.read_recover_ticks  <= 8'd50;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_RESET_LOW:     cfg.reset_low_ticks     <= pwdata[9:0];
        REG_RESET_RELEASE: cfg.reset_release_ticks <= pwdata[9:0];
        REG_PRES_WAIT:     cfg.presence_wait_ticks <= pwdata[9:0];
        REG_PRES_MAX:      cfg.presence_max_ticks  <= pwdata[9:0];
        REG_SLOT_SHORT:    cfg.slot_short_ticks    <= pwdata[7:0];
        REG_SLOT_LONG:     cfg.slot_long_ticks     <= pwdata[7:0];
        REG_READ_SAMPLE:   cfg.read_sample_ticks   <= pwdata[7:0];
        REG_READ_RECOVER:  cfg.read_recover_ticks  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_RESET_LOW:     prdata = DATA_W'(cfg.reset_low_ticks);
      REG_RESET_RELEASE: prdata = DATA_W'(cfg.reset_release_ticks);
      REG_PRES_WAIT:     prdata = DATA_W'(cfg.presence_wait_ticks);
      REG_PRES_MAX:      prdata = DATA_W'(cfg.presence_max_ticks);
      REG_SLOT_SHORT:    prdata = DATA_W'(cfg.slot_short_ticks);
      REG_SLOT_LONG:     prdata = DATA_W'(cfg.slot_long_ticks);
      REG_READ_SAMPLE:   prdata = DATA_W'(cfg.read_sample_ticks);
      REG_READ_RECOVER:  prdata = DATA_W'(cfg.read_recover_ticks);
      default:           prdata = '0;
    endcase
  end

  assign in_item.cmd        = cmd_t'(s_tuser);
  assign in_item.tx_byte    = s_tdata[7:0];
  assign in_item.line_level = s_tdata[8];

  owbm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  owbm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {3'b000, out_res};

endmodule

// File: bench/testbench.sv
module testbench;
  import owbm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int NUM_REGS    = 8;

  // How a side spaces its beats.
  localparam int IDLE_NONE   = 0;
  localparam int IDLE_FULL   = 1;
  localparam int IDLE_SPARSE = 2;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] tx;
    logic       line;
    logic       typed;
    result_t    want;
  } script_row_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [15:0]       s_tdata;
  logic [1:0]        s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [15:0]       m_tdata;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Shadow of the bus master.
  phase_t           ph;
  logic [CNT_W-1:0] tcount;
  logic [2:0]       bidx;
  logic [7:0]       shreg;
  logic             fflag;
  logic [7:0]       rx_held;
  logic [REG_W-1:0] cfg_regs [NUM_REGS];

  result_t     predicted_status [$];
  logic [31:0] pending_cfg [NUM_REGS];
  script_row_t bus_script [19];

  int send_mode = IDLE_NONE;
  int recv_mode = IDLE_NONE;
  int err_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int ops_done = 0;
  int pres_fails = 0;
  int rejects = 0;
  int settings_run = 0;
  logic in_op = 1'b0;
  logic held = 1'b0;

  one_wire_bus_master DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int draw_gap(input int mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 15);
      default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
    endcase
  endfunction

  // A zero setting counts as one tick; anything beyond the counter saturates.
  function automatic logic [CNT_W-1:0] eff_limit(input reg_idx_t idx);
    logic [REG_W-1:0] v;
    v = cfg_regs[idx];
    if (v == '0) return CNT_W'(1);
    if (32'(v) > 32'(CNT_MAX)) return CNT_MAX;
    return CNT_W'(v);
  endfunction

  function automatic logic tick_expired(input reg_idx_t idx);
    tcount = tcount + 1'b1;
    if (tcount >= eff_limit(idx)) begin
      tcount = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void close_operation(input logic failed);
    fflag = failed;
    ph = PH_IDLE;
    tcount = '0;
    bidx = '0;
  endfunction

  task automatic step_bus_master(input item_t it, output result_t r);
    logic     rej;
    logic     drv;
    logic     dn;
    reg_idx_t first_half;
    reg_idx_t second_half;
    rej = 1'b0;
    dn = 1'b0;
    if (it.cmd != CMD_TICK) begin
      if (ph != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        tcount = '0;
        bidx = '0;
        fflag = 1'b0;
        case (it.cmd)
          CMD_RESET: ph = PH_RST_LOW;
          CMD_WRITE: begin
            ph = PH_W_LOW;
            shreg = it.tx_byte;
          end
          default: begin
            ph = PH_R_LOW;
            shreg = '0;
          end
        endcase
      end
    end
    drv = (ph == PH_RST_LOW) || (ph == PH_W_LOW) || (ph == PH_R_LOW);
    // A one bit is a short low then a long high; a zero bit the other way round.
    if (shreg[0]) begin
      first_half = REG_SLOT_SHORT;
      second_half = REG_SLOT_LONG;
    end else begin
      first_half = REG_SLOT_LONG;
      second_half = REG_SLOT_SHORT;
    end
    case (ph)
      PH_RST_LOW: if (tick_expired(REG_RESET_LOW)) ph = PH_RST_REL;
      PH_RST_REL: if (tick_expired(REG_RESET_RELEASE)) ph = PH_PRES_WAIT;
      PH_PRES_WAIT: begin
        if (it.line_level) begin
          if (tick_expired(REG_PRES_WAIT)) begin
            close_operation(1'b1);
            dn = 1'b1;
          end
        end else begin
          ph = PH_PRES_LOW;
          tcount = CNT_W'(1);
          if (tcount >= eff_limit(REG_PRES_MAX)) begin
            close_operation(1'b1);
            dn = 1'b1;
          end
        end
      end
      PH_PRES_LOW: begin
        if (it.line_level) begin
          close_operation(1'b0);
          dn = 1'b1;
        end else if (tick_expired(REG_PRES_MAX)) begin
          close_operation(1'b1);
          dn = 1'b1;
        end
      end
      PH_W_LOW: if (tick_expired(first_half)) ph = PH_W_HIGH;
      PH_W_HIGH: begin
        if (tick_expired(second_half)) begin
          shreg = shreg >> 1;
          if (bidx == 3'd7) begin
            close_operation(1'b0);
            dn = 1'b1;
          end else begin
            bidx = bidx + 1'b1;
            ph = PH_W_LOW;
          end
        end
      end
      PH_R_LOW: if (tick_expired(REG_SLOT_SHORT)) ph = PH_R_WAIT;
      PH_R_WAIT: begin
        if (tick_expired(REG_READ_SAMPLE)) begin
          shreg = {it.line_level, shreg[7:1]};
          ph = PH_R_REC;
        end
      end
      PH_R_REC: begin
        if (tick_expired(REG_READ_RECOVER)) begin
          if (bidx == 3'd7) begin
            rx_held = shreg;
            close_operation(1'b0);
            dn = 1'b1;
          end else begin
            bidx = bidx + 1'b1;
            ph = PH_R_LOW;
          end
        end
      end
      default: ph = PH_IDLE;
    endcase
    r.drive_low = drv;
    r.busy_res = (ph != PH_IDLE);
    r.done_res = dn;
    r.presence_fail = dn && fflag;
    r.rx_byte = rx_held;
    r.cmd_rejected = rej;
  endtask

  task automatic apb_access(input logic wr, input int idx, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_W'(4 * idx);
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes every timing register from pending_cfg, then reads them all back.
  task automatic program_timing();
    logic [DATA_W-1:0] rd;
    for (int i = 0; i < NUM_REGS; i++) begin
      apb_access(1'b1, i, pending_cfg[i], rd);
      if (i < int'(REG_SLOT_SHORT)) cfg_regs[i] = pending_cfg[i][9:0];
      else cfg_regs[i] = {2'b00, pending_cfg[i][7:0]};
    end
    for (int i = 0; i < NUM_REGS; i++) begin
      apb_access(1'b0, i, '0, rd);
      if (rd !== DATA_W'(cfg_regs[i])) begin
        err_count++;
        $display("%0t: register %0d readback mismatch, expected %0h, got %0h",
                 $time, i, cfg_regs[i], rd);
      end
    end
    settings_run++;
  endtask

  task automatic send_beat(input item_t it, input logic typed, input result_t typed_res);
    int      gap;
    result_t r;
    gap = draw_gap(send_mode);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, it.line_level, it.tx_byte};
    s_tuser <= it.cmd;
    do @(posedge clk); while (!s_tready);
    step_bus_master(it, r);
    predicted_status.push_back(typed ? typed_res : r);
    items_sent++;
    if (r.done_res) ops_done++;
    if (r.presence_fail) pres_fails++;
    if (r.cmd_rejected) rejects++;
  endtask

  // Runs one command to completion. The line follows a device that answers a
  // reset after a random delay and holds presence for a random length.
  task automatic run_op(input cmd_t kind);
    item_t it;
    int    hi_left;
    int    lo_left;
    in_op = 1'b1;
    hi_left = $urandom_range(0, eff_limit(REG_PRES_WAIT));
    lo_left = $urandom_range(1, eff_limit(REG_PRES_MAX));
    it.cmd = kind;
    it.tx_byte = $urandom_range(0, 255);
    it.line_level = $urandom_range(0, 1);
    send_beat(it, 1'b0, '0);
    while (ph != PH_IDLE) begin
      it.cmd = ($urandom_range(0, 11) == 0) ? cmd_t'($urandom_range(1, 3)) : CMD_TICK;
      it.tx_byte = $urandom_range(0, 255);
      it.line_level = $urandom_range(0, 1);
      if (ph == PH_PRES_WAIT) begin
        if (hi_left > 0) begin
          it.line_level = 1'b1;
          hi_left--;
        end else begin
          it.line_level = 1'b0;
          lo_left--;
        end
      end else if (ph == PH_PRES_LOW) begin
        if (lo_left > 0) begin
          it.line_level = 1'b0;
          lo_left--;
        end else begin
          it.line_level = 1'b1;
        end
      end
      send_beat(it, 1'b0, '0);
    end
    in_op = 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (predicted_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // Result side: random ready gaps, one long hold-off while commands are running.
  initial begin
    int      gap;
    result_t got;
    result_t want;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (!held && in_op && results_seen >= 300) begin
        gap = 400;
        held = 1'b1;
      end else begin
        gap = draw_gap(recv_mode);
      end
      if (gap > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = result_t'(m_tdata[12:0]);
      results_seen++;
      if (predicted_status.size() == 0) begin
        err_count++;
        $display("%0t: result beat with nothing expected, expected none, got %0h",
                 $time, m_tdata);
      end else begin
        want = predicted_status.pop_front();
        check_field("drive_low", want.drive_low, got.drive_low);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("done_res", want.done_res, got.done_res);
        check_field("presence_fail", want.presence_fail, got.presence_fail);
        check_field("rx_byte", want.rx_byte, got.rx_byte);
        check_field("cmd_rejected", want.cmd_rejected, got.cmd_rejected);
        check_field("tdata padding", 0, m_tdata[15:13]);
      end
    end
  end

  initial begin
    item_t       it;
    logic [31:0] v;
    int          n_ops;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_TICK;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    ph = PH_IDLE;
    tcount = '0;
    bidx = '0;
    shreg = '0;
    fflag = 1'b0;
    rx_held = '0;
    cfg_regs[REG_RESET_LOW] = 10'd750;
    cfg_regs[REG_RESET_RELEASE] = 10'd15;
    cfg_regs[REG_PRES_WAIT] = 10'd200;
    cfg_regs[REG_PRES_MAX] = 10'd240;
    cfg_regs[REG_SLOT_SHORT] = 10'd2;
    cfg_regs[REG_SLOT_LONG] = 10'd60;
    cfg_regs[REG_READ_SAMPLE] = 10'd12;
    cfg_regs[REG_READ_RECOVER] = 10'd50;

    // Reset sequences with one-tick phases and a two-sample presence window:
    // idle ticks, no device, a good presence, presence held too long, a late
    // presence, and commands refused while busy.
    bus_script[0]  = '{CMD_TICK,  8'h00, 1'b1, 1'b1, '0};
    bus_script[1]  = '{CMD_TICK,  8'hFF, 1'b0, 1'b1, '0};
    bus_script[2]  = '{CMD_RESET, 8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1}};
    bus_script[3]  = '{CMD_WRITE, 8'h5A, 1'b1, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0}};
    bus_script[4]  = '{CMD_TICK,  8'h00, 1'b1, 1'b0, '0};
    bus_script[5]  = '{CMD_TICK,  8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0}};
    bus_script[6]  = '{CMD_RESET, 8'h00, 1'b0, 1'b0, '0};
    bus_script[7]  = '{CMD_TICK,  8'h00, 1'b1, 1'b0, '0};
    bus_script[8]  = '{CMD_TICK,  8'h00, 1'b0, 1'b0, '0};
    bus_script[9]  = '{CMD_TICK,  8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0}};
    bus_script[10] = '{CMD_RESET, 8'h00, 1'b1, 1'b0, '0};
    bus_script[11] = '{CMD_READ,  8'h00, 1'b1, 1'b0, '0};
    bus_script[12] = '{CMD_TICK,  8'h00, 1'b0, 1'b0, '0};
    bus_script[13] = '{CMD_TICK,  8'h00, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0}};
    bus_script[14] = '{CMD_RESET, 8'hA5, 1'b1, 1'b0, '0};
    bus_script[15] = '{CMD_RESET, 8'h00, 1'b1, 1'b0, '0};
    bus_script[16] = '{CMD_TICK,  8'h00, 1'b1, 1'b0, '0};
    bus_script[17] = '{CMD_TICK,  8'h00, 1'b0, 1'b0, '0};
    bus_script[18] = '{CMD_TICK,  8'h00, 1'b1, 1'b0, '0};

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_REGS; i++) pending_cfg[i] = '0;
    pending_cfg[REG_PRES_WAIT] = 32'd2;
    pending_cfg[REG_PRES_MAX] = 32'd2;
    program_timing();
    foreach (bus_script[i]) begin
      it.cmd = bus_script[i].cmd;
      it.tx_byte = bus_script[i].tx;
      it.line_level = bus_script[i].line;
      send_beat(it, bus_script[i].typed, bus_script[i].want);
    end
    settle();

    // Short random timings, with stray upper bits now and then to check masking.
    while (items_sent < 1020) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 6);
        if ($urandom_range(0, 4) == 0)
          v = v | ($urandom() << ((i < int'(REG_SLOT_SHORT)) ? 10 : 8));
        pending_cfg[i] = v;
      end
      program_timing();
      send_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
      recv_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
      n_ops = $urandom_range(2, 5);
      repeat (n_ops) begin
        repeat ($urandom_range(0, 3)) begin
          it.cmd = CMD_TICK;
          it.tx_byte = $urandom_range(0, 255);
          it.line_level = $urandom_range(0, 1);
          send_beat(it, 1'b0, '0);
        end
        run_op(cmd_t'($urandom_range(1, 3)));
      end
      settle();
    end

    // Every register at its largest value for a readback check, then every
    // register at zero with full operations.
    for (int i = 0; i < NUM_REGS; i++) pending_cfg[i] = 32'hFFFF_FFFF;
    program_timing();

    for (int i = 0; i < NUM_REGS; i++) pending_cfg[i] = '0;
    program_timing();
    send_mode = IDLE_FULL;
    recv_mode = IDLE_SPARSE;
    run_op(CMD_RESET);
    run_op(CMD_WRITE);
    run_op(CMD_READ);
    run_op(CMD_READ);
    settle();

    repeat (8) @(posedge clk);
    if (predicted_status.size() != 0) begin
      err_count++;
      $display("%0t: results missing at the end, expected %0d more, got 0",
               $time, predicted_status.size());
    end
    $display("Ran %0d input beats and checked %0d result beats over %0d timing settings.",
             items_sent, results_seen, settings_run);
    $display("Finished %0d operations (%0d presence failures); refused %0d busy commands.",
             ops_done, pres_fails, rejects);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/owbm_pkg.sv
rtl/owbm_front.sv
rtl/owbm_engine.sv
rtl/one_wire_bus_master.sv
bench/testbench.sv
